// ----- src/fde_pkg.sv -----
// Package with the shared constants and field types of the frame delta encoder.
`timescale 1ns / 1ps
`default_nettype none

package fde_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 2;
    localparam int WELL_CNT_W = 13;
    localparam int FRAME_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [BYTE_W-1:0]   delta_byte_t;
    typedef logic [KIND_W-1:0]          kind_t;
    typedef logic [FRAME_W-1:0]         frame_idx_t;

    localparam kind_t KIND_RAW    = 2'd0;
    localparam kind_t KIND_DELTA  = 2'd1;
    localparam kind_t KIND_ESCAPE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WELL_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 1'd1;

    localparam logic [WELL_CNT_W-1:0] WELL_COUNT_RESET  = 13'd4096;
    localparam frame_idx_t            FRAME_COUNT_RESET = 16'd1;

    localparam delta_byte_t ESCAPE_BYTE = 8'sd127;
    localparam sample_t     ESCAPE_HIGH = 16'sd127;
    localparam sample_t     ESCAPE_LOW  = -16'sd127;

endpackage

`default_nettype wire

// ----- src/fde_if.sv -----
// Stream interfaces for the sample input and the encoded result output.
`timescale 1ns / 1ps
`default_nettype none

interface fde_sample_if;
    logic             valid;
    logic             ready;
    fde_pkg::sample_t sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

interface fde_result_if;
    logic                 valid;
    logic                 ready;
    fde_pkg::kind_t       item_kind;
    fde_pkg::delta_byte_t delta_byte;
    fde_pkg::sample_t     full_word;
    logic                 chunk_end;

    modport source (output valid, output item_kind, output delta_byte,
                    output full_word, output chunk_end, input ready);
    modport sink   (input valid, input item_kind, input delta_byte,
                    input full_word, input chunk_end, output ready);
endinterface

`default_nettype wire

// ----- src/fde_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module fde_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/frame_delta_encoder_escape_top.sv -----
// Top level of the frame delta encoder with escape code.
// An accepted sample beat moves through the s1 register, then the output register as a result beat.
// Throughput: one sample beat per cycle unless result_out stalls, set by the frame
// store read port, whose registered read data feeds a single subtract and range compare.
// Reset clears the well and frame counters and loads the register defaults;
// the frame store is not cleared, since the first frame writes every entry later read.
`timescale 1ns / 1ps
`default_nettype none

module frame_delta_encoder_escape_top #(
    parameter int MAX_WELLS = 4096
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [fde_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [fde_pkg::CFG_DATA_W-1:0]    cfg_data,
    fde_sample_if.sink                             sample_in,
    fde_result_if.source                           result_out
);

    localparam int AW = (MAX_WELLS > 1) ? $clog2(MAX_WELLS) : 1;
    localparam int CW = ((AW > fde_pkg::WELL_CNT_W) ? AW : fde_pkg::WELL_CNT_W) + 1;
    localparam int FW = fde_pkg::FRAME_W + 1;

    logic [fde_pkg::WELL_CNT_W-1:0] well_count_reg;
    fde_pkg::frame_idx_t            frame_count_reg;
    logic [AW-1:0]                  well_index_reg, well_index_next;
    fde_pkg::frame_idx_t            frame_index_reg, frame_index_next;

    logic                 s1_valid_reg;
    fde_pkg::sample_t     s1_sample_reg;
    logic                 s1_first_reg;
    logic                 s1_end_reg;

    logic                 out_valid_reg;
    fde_pkg::kind_t       out_kind_reg, out_kind_next;
    fde_pkg::delta_byte_t out_byte_reg, out_byte_next;
    fde_pkg::sample_t     out_word_reg, out_word_next;
    logic                 out_end_reg;

    logic             accept;
    logic             advance;
    logic [CW-1:0]    wells;
    logic [CW-1:0]    well_plus_one;
    logic [FW-1:0]    frames;
    logic [FW-1:0]    frame_plus_one;
    logic             last_well;
    logic             last_frame;
    fde_pkg::sample_t prev_sample;
    fde_pkg::sample_t diff;

    assign advance          = s1_valid_reg && (!out_valid_reg || result_out.ready);
    assign sample_in.ready  = !s1_valid_reg || advance;
    assign accept           = sample_in.valid && sample_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            well_count_reg  <= fde_pkg::WELL_COUNT_RESET;
            frame_count_reg <= fde_pkg::FRAME_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fde_pkg::REG_WELL_COUNT:
                begin
                    well_count_reg <= cfg_data[fde_pkg::WELL_CNT_W-1:0];
                end
                fde_pkg::REG_FRAME_COUNT:
                begin
                    frame_count_reg <= cfg_data[fde_pkg::FRAME_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // A zero count acts as one; the well count is clipped to the store depth.
    always_comb
    begin
        if (well_count_reg == '0)
        begin
            wells = CW'(1);
        end
        else if (CW'(well_count_reg) > CW'(MAX_WELLS))
        begin
            wells = CW'(MAX_WELLS);
        end
        else
        begin
            wells = CW'(well_count_reg);
        end
        frames = (frame_count_reg == '0) ? FW'(1) : FW'(frame_count_reg);

        well_plus_one  = CW'(well_index_reg) + CW'(1);
        frame_plus_one = FW'(frame_index_reg) + FW'(1);
        last_well      = well_plus_one >= wells;
        last_frame     = frame_plus_one >= frames;

        if (last_well)
        begin
            well_index_next  = '0;
            frame_index_next = last_frame ? '0 : frame_plus_one[fde_pkg::FRAME_W-1:0];
        end
        else
        begin
            well_index_next  = well_plus_one[AW-1:0];
            frame_index_next = frame_index_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            well_index_reg  <= '0;
            frame_index_reg <= '0;
        end
        else if (accept)
        begin
            well_index_reg  <= well_index_next;
            frame_index_reg <= frame_index_next;
        end
    end

    // The store read returns the old entry, then the same beat overwrites it.
    fde_ram #(
        .WIDTH (fde_pkg::SAMPLE_W),
        .DEPTH (MAX_WELLS)
    ) u_frame_store (
        .clk   (clk),
        .we    (accept),
        .waddr (well_index_reg),
        .wdata (sample_in.sample_value),
        .re    (accept),
        .raddr (well_index_reg),
        .rdata (prev_sample)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= sample_in.sample_value;
            s1_first_reg  <= (frame_index_reg == '0);
            s1_end_reg    <= last_well && last_frame;
        end
    end

    always_comb
    begin
        diff = s1_sample_reg - prev_sample;
        if (s1_first_reg)
        begin
            out_kind_next = fde_pkg::KIND_RAW;
            out_byte_next = '0;
            out_word_next = s1_sample_reg;
        end
        else if (diff >= fde_pkg::ESCAPE_HIGH || diff <= fde_pkg::ESCAPE_LOW)
        begin
            out_kind_next = fde_pkg::KIND_ESCAPE;
            out_byte_next = fde_pkg::ESCAPE_BYTE;
            out_word_next = diff;
        end
        else
        begin
            out_kind_next = fde_pkg::KIND_DELTA;
            out_byte_next = diff[fde_pkg::BYTE_W-1:0];
            out_word_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_kind_reg <= out_kind_next;
            out_byte_reg <= out_byte_next;
            out_word_reg <= out_word_next;
            out_end_reg  <= s1_end_reg;
        end
    end

    assign result_out.valid      = out_valid_reg;
    assign result_out.item_kind  = out_kind_reg;
    assign result_out.delta_byte = out_byte_reg;
    assign result_out.full_word  = out_word_reg;
    assign result_out.chunk_end  = out_end_reg;

endmodule

`default_nettype wire

// ----- src/fde_checker.sv -----
// Port-level checker for the frame delta encoder and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fde_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire fde_pkg::kind_t       item_kind,
    input wire fde_pkg::delta_byte_t delta_byte,
    input wire fde_pkg::sample_t     full_word,
    input wire logic                 chunk_end
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(item_kind)
            && $stable(delta_byte) && $stable(full_word) && $stable(chunk_end))
        else $error("Stalled result beat changed.");

    a_raw_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind == fde_pkg::KIND_RAW |-> delta_byte == '0)
        else $error("Raw word carries a nonzero delta byte.");

    a_delta_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind == fde_pkg::KIND_DELTA |->
            delta_byte != fde_pkg::ESCAPE_BYTE && delta_byte != -8'sd127
            && delta_byte != -8'sd128 && full_word == '0)
        else $error("Delta byte outside its range or word not cleared.");

    a_escape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind == fde_pkg::KIND_ESCAPE |->
            delta_byte == fde_pkg::ESCAPE_BYTE
            && (full_word >= fde_pkg::ESCAPE_HIGH || full_word <= fde_pkg::ESCAPE_LOW))
        else $error("Escape beat with a wrong byte or an in-range word.");

endmodule

bind frame_delta_encoder_escape_top fde_checker u_fde_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (result_out.valid),
    .out_ready  (result_out.ready),
    .item_kind  (result_out.item_kind),
    .delta_byte (result_out.delta_byte),
    .full_word  (result_out.full_word),
    .chunk_end  (result_out.chunk_end)
);

`default_nettype wire
